FILE: sv/pwe_pkg.sv
// Package for the periodic waveform evaluator: defaults, command codes, item types.
package pwe_pkg;

   localparam int SINE_TABLE_DEPTH_DEFAULT = 256;
   localparam int FRAC_BITS_DEFAULT        = 16;

   // pi/2 in Q30
   localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

   localparam logic [2:0] CMD_SINE     = 3'd0;
   localparam logic [2:0] CMD_SQUARE   = 3'd1;
   localparam logic [2:0] CMD_SAW      = 3'd2;
   localparam logic [2:0] CMD_INV_SAW  = 3'd3;
   localparam logic [2:0] CMD_TRIANGLE = 3'd4;
   localparam logic [2:0] CMD_NOISE    = 3'd5;

   typedef struct packed {
      logic [2:0]         command;
      logic [31:0]        time_now;
      logic signed [31:0] base;
      logic signed [31:0] amplitude;
      logic signed [31:0] phase;
      logic signed [31:0] frequency;
   } pwe_req_type;

   typedef struct packed {
      logic signed [31:0] value;
      logic               unsupported;
   } pwe_rsp_type;

endpackage

FILE: sv/periodic_waveform_evaluator_unit.sv
// Periodic waveform evaluator: five-stage pipeline from request item to result item.
//
// Usage: one request item (command, time, base, amplitude, phase, frequency)
// on the req_ channel gives exactly one result item (value, unsupported) on
// the rsp_ channel, in order. Both channels use valid/ready; an item moves
// when valid and ready are high at a rising clock edge.
// A request item passes through the stage registers in order before its result item is valid.
// Throughput: one item per cycle unless rsp_ready holds the output. The stages are:
// time x frequency multiply, phase add and sine quadrant split, sine table read and
// waveform shaping, amplitude multiply, scale/add/saturate into the output register.
// Each stage has its own valid bit and moves whenever the stage after it is
// empty or moving, so a stalled receiver holds up to five items and bubbles
// are squeezed out; req_ready drops only when all stages are full and the
// output item is not taken.
// Reset (synchronous, active high) clears all valid bits; items in flight
// are dropped. The sine table is a constant and needs no setup.
module periodic_waveform_evaluator_unit #(
   parameter int SINE_TABLE_DEPTH = pwe_pkg::SINE_TABLE_DEPTH_DEFAULT,
   parameter int FRAC_BITS        = pwe_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  pwe_pkg::pwe_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output pwe_pkg::pwe_rsp_type rsp_data
);
   import pwe_pkg::*;

   localparam int NSTAGES = 5;
   localparam int IDX_W   = $clog2(4 * SINE_TABLE_DEPTH);
   localparam int ADDR_W  = $clog2(SINE_TABLE_DEPTH + 1);
   localparam int YW      = FRAC_BITS + 2;
   localparam int PW      = YW + 32;

   localparam logic [FRAC_BITS+IDX_W-1:0] IDX_SCALE = (FRAC_BITS+IDX_W)'(4 * SINE_TABLE_DEPTH);
   localparam logic [IDX_W-1:0]  Q1_START = IDX_W'(SINE_TABLE_DEPTH);
   localparam logic [IDX_W-1:0]  Q2_START = IDX_W'(2 * SINE_TABLE_DEPTH);
   localparam logic [IDX_W-1:0]  Q3_START = IDX_W'(3 * SINE_TABLE_DEPTH);
   localparam logic [ADDR_W-1:0] DEPTH_A  = ADDR_W'(SINE_TABLE_DEPTH);
   localparam logic [FRAC_BITS+2:0] ONE_W   = {3'b001, {FRAC_BITS{1'b0}}};
   localparam logic [FRAC_BITS+2:0] THREE_W = {3'b011, {FRAC_BITS{1'b0}}};
   localparam logic [FRAC_BITS:0]   ROM_ONE = {1'b1, {FRAC_BITS{1'b0}}};
   localparam logic signed [34:0] SAT_MAX = 35'sd2147483647;
   localparam logic signed [34:0] SAT_MIN = -35'sd2147483648;

   // quarter-wave sine table, built at elaboration (Q30 Taylor series, rounded)
   logic [FRAC_BITS:0] sine_rom [SINE_TABLE_DEPTH+1];

   for (genvar i = 0; i <= SINE_TABLE_DEPTH; i++) begin : g_rom
      localparam longint unsigned TH  = (HALF_PI_Q30 * longint'(i)) / SINE_TABLE_DEPTH;
      localparam longint unsigned TH2 = (TH * TH) >> 30;
      localparam longint unsigned M1  = ((TH * TH2) >> 30) / 6;
      localparam longint unsigned M2  = ((M1 * TH2) >> 30) / 20;
      localparam longint unsigned M3  = ((M2 * TH2) >> 30) / 42;
      localparam longint unsigned M4  = ((M3 * TH2) >> 30) / 72;
      localparam longint unsigned M5  = ((M4 * TH2) >> 30) / 110;
      localparam longint unsigned M6  = ((M5 * TH2) >> 30) / 156;
      localparam longint unsigned M7  = ((M6 * TH2) >> 30) / 210;
      localparam longint unsigned M8  = ((M7 * TH2) >> 30) / 272;
      localparam longint SUM = longint'(TH) - longint'(M1) + longint'(M2) - longint'(M3)
                             + longint'(M4) - longint'(M5) + longint'(M6) - longint'(M7)
                             + longint'(M8);
      localparam longint unsigned SPOS = (SUM < 0) ? 64'd0 : longint'(SUM);
      localparam longint unsigned RND  =
         (SPOS + (64'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS);
      localparam longint unsigned ENT  = (RND > (64'd1 << FRAC_BITS)) ?
                                         (64'd1 << FRAC_BITS) : RND;
      assign sine_rom[i] = ENT[FRAC_BITS:0];
   end

   // pipeline flow control
   logic [NSTAGES-1:0] stage_valid_ff;
   logic [NSTAGES-1:0] stage_adv;

   always_comb begin
      stage_adv[NSTAGES-1] = !stage_valid_ff[NSTAGES-1] || rsp_ready;
      for (int k = NSTAGES - 2; k >= 0; k--) begin
         stage_adv[k] = !stage_valid_ff[k] || stage_adv[k+1];
      end
   end

   assign req_ready = stage_adv[0];
   assign rsp_valid = stage_valid_ff[NSTAGES-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= '0;
      end else begin
         if (stage_adv[0]) begin
            stage_valid_ff[0] <= req_valid;
         end
         for (int k = 1; k < NSTAGES; k++) begin
            if (stage_adv[k]) begin
               stage_valid_ff[k] <= stage_valid_ff[k-1];
            end
         end
      end
   end

   // stage 1: time x frequency
   logic signed [64:0]        mult_full;
   logic [FRAC_BITS-1:0]      s1_frac_in;
   logic [2:0]                s1_cmd_ff;
   logic [FRAC_BITS-1:0]      s1_frac_ff;
   logic [FRAC_BITS-1:0]      s1_ph_ff;
   logic signed [31:0]        s1_base_ff;
   logic signed [31:0]        s1_amp_ff;

   assign mult_full  = $signed({1'b0, req_data.time_now}) * req_data.frequency;
   assign s1_frac_in = mult_full[2*FRAC_BITS-1:FRAC_BITS];

   always_ff @(posedge clock) begin
      if (stage_adv[0]) begin
         s1_cmd_ff  <= req_data.command;
         s1_frac_ff <= s1_frac_in;
         s1_ph_ff   <= req_data.phase[FRAC_BITS-1:0];
         s1_base_ff <= req_data.base;
         s1_amp_ff  <= req_data.amplitude;
      end
   end

   // stage 2: phase, sine quadrant and table address
   logic [FRAC_BITS-1:0]       x_in;
   logic [FRAC_BITS+IDX_W-1:0] idx_full;
   logic [IDX_W-1:0]           idx;
   logic [IDX_W-1:0]           offset;
   logic [1:0]                 quad;
   logic [ADDR_W-1:0]          addr_in;
   logic [2:0]                 s2_cmd_ff;
   logic [FRAC_BITS-1:0]       s2_x_ff;
   logic [ADDR_W-1:0]          s2_addr_ff;
   logic                       s2_neg_ff;
   logic signed [31:0]         s2_base_ff;
   logic signed [31:0]         s2_amp_ff;

   always_comb begin
      x_in     = s1_frac_ff + s1_ph_ff;
      idx_full = {{IDX_W{1'b0}}, x_in} * IDX_SCALE;
      idx      = idx_full[FRAC_BITS+IDX_W-1:FRAC_BITS];
      if (idx >= Q3_START) begin
         quad   = 2'd3;
         offset = idx - Q3_START;
      end else if (idx >= Q2_START) begin
         quad   = 2'd2;
         offset = idx - Q2_START;
      end else if (idx >= Q1_START) begin
         quad   = 2'd1;
         offset = idx - Q1_START;
      end else begin
         quad   = 2'd0;
         offset = idx;
      end
      addr_in = quad[0] ? DEPTH_A - offset[ADDR_W-1:0] : offset[ADDR_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (stage_adv[1]) begin
         s2_cmd_ff  <= s1_cmd_ff;
         s2_x_ff    <= x_in;
         s2_addr_ff <= addr_in;
         s2_neg_ff  <= quad[1];
         s2_base_ff <= s1_base_ff;
         s2_amp_ff  <= s1_amp_ff;
      end
   end

   // stage 3: sine table read, other waveforms
   logic [FRAC_BITS+2:0]      x4;
   logic [FRAC_BITS+2:0]      wave_wide;
   logic                      sine_in;
   logic                      bad_in;
   logic [FRAC_BITS:0]        s3_rom_ff;
   logic signed [YW-1:0]      s3_wave_ff;
   logic                      s3_sine_ff;
   logic                      s3_neg_ff;
   logic                      s3_bad_ff;
   logic signed [31:0]        s3_base_ff;
   logic signed [31:0]        s3_amp_ff;

   always_comb begin
      x4        = {1'b0, s2_x_ff, 2'b00};
      wave_wide = '0;
      sine_in   = 1'b0;
      bad_in    = 1'b0;
      case (s2_cmd_ff)
         CMD_SINE: begin
            sine_in = 1'b1;
         end
         CMD_SQUARE: begin
            wave_wide = s2_x_ff[FRAC_BITS-1] ? ('0 - ONE_W) : ONE_W;
         end
         CMD_SAW: begin
            wave_wide = {3'b000, s2_x_ff};
         end
         CMD_INV_SAW: begin
            wave_wide = ONE_W - {3'b000, s2_x_ff};
         end
         CMD_TRIANGLE: begin
            wave_wide = s2_x_ff[FRAC_BITS-1] ? (THREE_W - x4) : (x4 - ONE_W);
         end
         default: begin
            bad_in = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (stage_adv[2]) begin
         s3_rom_ff  <= sine_rom[s2_addr_ff];
         s3_wave_ff <= $signed(wave_wide[YW-1:0]);
         s3_sine_ff <= sine_in;
         s3_neg_ff  <= s2_neg_ff;
         s3_bad_ff  <= bad_in;
         s3_base_ff <= s2_base_ff;
         s3_amp_ff  <= s2_amp_ff;
      end
   end

   // stage 4: amplitude multiply
   logic signed [YW-1:0] rom_ext;
   logic signed [YW-1:0] y_in;
   logic signed [PW-1:0] prod_in;
   logic signed [PW-1:0] s4_prod_ff;
   logic                 s4_bad_ff;
   logic signed [31:0]   s4_base_ff;

   always_comb begin
      rom_ext = $signed({1'b0, s3_rom_ff});
      if (s3_sine_ff) begin
         y_in = s3_neg_ff ? -rom_ext : rom_ext;
      end else begin
         y_in = s3_wave_ff;
      end
      prod_in = y_in * s3_amp_ff;
   end

   always_ff @(posedge clock) begin
      if (stage_adv[3]) begin
         s4_prod_ff <= prod_in;
         s4_bad_ff  <= s3_bad_ff;
         s4_base_ff <= s3_base_ff;
      end
   end

   // stage 5: floor scale, add base, saturate
   logic signed [33:0]  scaled;
   logic signed [34:0]  sum;
   pwe_rsp_type         rsp_in;
   pwe_rsp_type         rsp_ff;

   always_comb begin
      scaled = s4_prod_ff[PW-1:FRAC_BITS];
      sum    = $signed({{3{s4_base_ff[31]}}, s4_base_ff}) + $signed({scaled[33], scaled});
      rsp_in.unsupported = s4_bad_ff;
      if (s4_bad_ff) begin
         rsp_in.value = s4_base_ff;
      end else if (sum > SAT_MAX) begin
         rsp_in.value = SAT_MAX[31:0];
      end else if (sum < SAT_MIN) begin
         rsp_in.value = SAT_MIN[31:0];
      end else begin
         rsp_in.value = sum[31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (stage_adv[4]) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_data = rsp_ff;

   // checks
   a_full_blocks_input: assert property (@(posedge clock) disable iff (reset)
      (stage_valid_ff == '1) && !rsp_ready |-> !req_ready)
      else $error("input taken while pipeline full and output stalled");

   a_unsupported_gives_base: assert property (@(posedge clock) disable iff (reset)
      stage_valid_ff[3] && stage_adv[4] && s4_bad_ff
      |=> rsp_data.unsupported && (rsp_data.value == $past(s4_base_ff)))
      else $error("unsupported item did not return base");

   a_sine_in_range: assert property (@(posedge clock) disable iff (reset)
      stage_valid_ff[2] && s3_sine_ff |-> s3_rom_ff <= ROM_ONE)
      else $error("sine table entry above one");

endmodule
